@@ src/open_address_key_table_macros.svh @@
`ifndef OPEN_ADDRESS_KEY_TABLE_MACROS_SVH
`define OPEN_ADDRESS_KEY_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OAKT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OAKT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/oakt_pkg.sv @@
package oakt_pkg;

  localparam int CMD_W      = 2;
  localparam int KEY_W      = 32;
  localparam int SLOT_W     = 10;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 11;
  localparam int SIZE_W     = 11;
  localparam int OUT_DATA_W = 56;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;

  // word index of the size register
  localparam logic REG_TABLE_SIZE = 1'b0;

endpackage

@@ src/oakt_mod.sv @@
module oakt_mod
  import oakt_pkg::*;
#(
  parameter int KW = 32,
  parameter int ZW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [KW-1:0] dividend,
  input  logic [ZW-1:0] divisor,
  output logic          done,
  output logic [ZW-1:0] rem
);

  localparam int CW = $clog2(KW + 1);

  logic [KW-1:0] quo_r, quo_nxt;
  logic [ZW-1:0] rem_r, rem_nxt;
  logic [ZW-1:0] dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [ZW:0]   trial;

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem_r, quo_r[KW-1]};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CW'(KW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quo_nxt = quo_r << 1;
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = ZW'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = ZW'(trial);
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ src/oakt_ram.sv @@
module oakt_ram
  import oakt_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/open_address_key_table.sv @@
// Channel | Dir | Handshake                  | Payload
// in_     | in  | in_tvalid / in_tready      | tuser command, tdata key
// out_    | out | out_tvalid / out_tready    | tuser status, tdata key/slot/occupancy
// cfg_    | in  | APB psel/penable, pready=1 | table_size at byte address 0
//
// After reset the slot memory is swept to zero, one slot a cycle, with in_tready low.
// A request is taken in S_IDLE, runs the key remainder on the shared bit-serial remainder unit
// (allocate runs it again for each skipped multiple of the size), probes one slot a cycle
// (one read port of the slot memory), and hands off the result from S_DONE.
// A result waits in the output register while the next request runs; that request then holds
// in its last cycle, in_tready low, until the output register is taken.
`include "open_address_key_table_macros.svh"

module open_address_key_table
  import oakt_pkg::*;
#(
  parameter int SLOTS    = 1024,
  parameter int KEY_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [KEY_W-1:0]      in_tdata,    // [31:0] key
  input  logic [CMD_W-1:0]      in_tuser,    // [1:0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [31:0] result_key, [41:32] slot,
                                             // [52:42] occupancy, [55:53] zero
  output logic [STATUS_W-1:0]   out_tuser,   // [1:0] status
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SW = $clog2(SLOTS);
  localparam int ZW = $clog2(SLOTS + 1);
  localparam int KW = KEY_BITS;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_PROBE, S_DONE} state_t;

  state_t              state_r, state_nxt;
  logic [SW-1:0]       clr_addr_r, clr_addr_nxt;
  logic [SIZE_W-1:0]   tsize_r, tsize_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KW-1:0]       cand_r, cand_nxt;
  logic [KW-1:0]       last_r, last_nxt;
  logic [ZW-1:0]       occ_r, occ_nxt;
  logic [SW-1:0]       step_r, step_nxt;
  logic [SW-1:0]       pos_r, pos_nxt;
  logic [KW-1:0]       res_key_r, res_key_nxt;
  logic [SW-1:0]       res_slot_r, res_slot_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [OCC_W-1:0]    out_occ_r, out_occ_nxt;

  logic [ZW-1:0]       size_w;
  logic [KW-1:0]       key_in;
  logic [KW-1:0]       target;
  logic [ZW:0]         pos_sum;
  logic [SW-1:0]       pos_next;
  logic                cfg_wr;
  logic                cfg_hit;

  logic                mod_start;
  logic [KW-1:0]       mod_dividend;
  logic                mod_done;
  logic [ZW-1:0]       mod_rem;

  logic                ram_we;
  logic [SW-1:0]       ram_waddr;
  logic [KW-1:0]       ram_wdata;
  logic [SW-1:0]       ram_raddr;
  logic [KW-1:0]       ram_rdata;

  oakt_mod #(.KW(KW), .ZW(ZW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (size_w),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  oakt_ram #(.DEPTH(SLOTS), .WIDTH(KW), .AW(SW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // size clamped to 2..SLOTS
  always_comb begin
    if (tsize_r < SIZE_W'(2)) begin
      size_w = ZW'(2);
    end else if (32'(tsize_r) > 32'(SLOTS)) begin
      size_w = ZW'(SLOTS);
    end else begin
      size_w = ZW'(tsize_r);
    end
  end

  assign cfg_hit    = (cfg_paddr[CFG_ADDR_W-1:2] == REG_TABLE_SIZE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(tsize_r) : '0;

  assign key_in   = KW'(in_tdata);
  assign target   = (cmd_r == CMD_ALLOC) ? '0 : cand_r;
  assign pos_sum  = (ZW + 1)'(pos_r) + (ZW + 1)'(step_r);
  assign pos_next = (pos_sum >= (ZW + 1)'(size_w)) ? SW'(pos_sum - (ZW + 1)'(size_w))
                                                    : SW'(pos_sum);

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    tsize_nxt      = tsize_r;
    cmd_nxt        = cmd_r;
    cand_nxt       = cand_r;
    last_nxt       = last_r;
    occ_nxt        = occ_r;
    step_nxt       = step_r;
    pos_nxt        = pos_r;
    res_key_nxt    = res_key_r;
    res_slot_nxt   = res_slot_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r;
    out_key_nxt    = out_key_r;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    mod_start      = 1'b0;
    mod_dividend   = cand_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = '0;
    ram_raddr      = pos_r;

    if (cfg_wr && cfg_hit) begin
      tsize_nxt = cfg_pwdata[SIZE_W-1:0];
    end
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == SW'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt      = in_tuser;
          res_slot_nxt = '0;
          case (in_tuser)
            CMD_ALLOC: begin
              res_key_nxt    = '0;
              res_status_nxt = ST_FULL;
              if (occ_r < size_w) begin
                cand_nxt     = last_r + KW'(1);
                mod_start    = 1'b1;
                mod_dividend = cand_nxt;
                state_nxt    = S_MOD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            CMD_LOOKUP, CMD_DELETE: begin
              res_key_nxt    = key_in;
              res_status_nxt = ST_NOT_FOUND;
              if (key_in != '0) begin
                cand_nxt     = key_in;
                mod_start    = 1'b1;
                mod_dividend = key_in;
                state_nxt    = S_MOD;
              end else begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              res_key_nxt    = key_in;
              res_status_nxt = ST_NOT_FOUND;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_done) begin
          if (cmd_r == CMD_ALLOC && mod_rem == '0) begin
            // multiples of the size are never issued
            cand_nxt     = cand_r + KW'(1);
            mod_start    = 1'b1;
            mod_dividend = cand_nxt;
          end else begin
            step_nxt  = SW'(mod_rem);
            pos_nxt   = SW'(mod_rem);
            ram_raddr = SW'(mod_rem);
            state_nxt = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        if (ram_rdata == target) begin
          res_key_nxt    = cand_r;
          res_slot_nxt   = pos_r;
          res_status_nxt = ST_DONE;
          state_nxt      = S_DONE;
          if (cmd_r == CMD_ALLOC) begin
            ram_we    = 1'b1;
            ram_wdata = cand_r;
            occ_nxt   = occ_r + 1'b1;
            last_nxt  = cand_r;
          end else if (cmd_r == CMD_DELETE) begin
            ram_we = 1'b1;
            if (occ_r != '0) begin
              occ_nxt = occ_r - 1'b1;
            end
          end
        end else if (pos_next == step_r) begin
          state_nxt = S_DONE;
        end else begin
          pos_nxt   = pos_next;
          ram_raddr = pos_next;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_key_nxt    = KEY_W'(res_key_r);
          out_slot_nxt   = SLOT_W'(res_slot_r);
          out_status_nxt = res_status_r;
          out_occ_nxt    = OCC_W'(occ_r);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      tsize_r     <= SIZE_RESET;
      last_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      tsize_r     <= tsize_nxt;
      last_r      <= last_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    cand_r       <= cand_nxt;
    step_r       <= step_nxt;
    pos_r        <= pos_nxt;
    res_key_r    <= res_key_nxt;
    res_slot_r   <= res_slot_nxt;
    res_status_r <= res_status_nxt;
    out_key_r    <= out_key_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_occ_r, out_slot_r, out_key_r};
  assign out_tuser  = out_status_r;

  `OAKT_ASSERT_IMP(a_occ_bound, 1'b1, occ_r <= ZW'(SLOTS), "occupancy above slot count")
  `OAKT_ASSERT_IMP(a_probe_range, state_r == S_PROBE, ZW'(pos_r) < size_w, "probe outside table")
  `OAKT_ASSERT_NXT(a_busy_after_req, in_tvalid && in_tready, !in_tready, "ready right after request")
  `OAKT_ASSERT_IMP(a_miss_slot_zero, out_valid_r && out_status_r != ST_DONE, out_slot_r == '0, "miss with slot")

endmodule

@@ tb/sv/open_address_key_table_checker.sv @@
module open_address_key_table_checker
  import oakt_pkg::*;
#(
  parameter int SLOTS = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [KEY_W-1:0]      in_tdata,
  input  logic [CMD_W-1:0]      in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [STATUS_W-1:0]   out_tuser,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  input  logic                  cfg_pready,
  output int                    results_seen,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] SIZE_ADDR = {REG_TABLE_SIZE, 2'b00};
  localparam int OCC_LSB = KEY_W + SLOT_W;
  localparam int PAD_LSB = KEY_W + SLOT_W + OCC_W;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occ;
  } table_reply_t;

  bit [KEY_W-1:0]  key_store [SLOTS];
  int unsigned     stored_count;
  bit [KEY_W-1:0]  key_counter;
  bit [SIZE_W-1:0] size_setting;
  table_reply_t    replies_due [$];

  function automatic int unsigned active_span();
    if (size_setting < 2) return 2;
    if (size_setting > SLOTS) return SLOTS;
    return size_setting;
  endfunction

  // walks key's probe cycle looking for target (0 = empty slot)
  function automatic bit walk_probe(input bit [KEY_W-1:0] key, input bit [KEY_W-1:0] target,
                                    input int unsigned span, output int unsigned where);
    int unsigned step;
    int unsigned pos;
    step = key % span;
    pos = step;
    where = 0;
    do begin
      if (key_store[pos] == target) begin
        where = pos;
        return 1'b1;
      end
      pos = (pos + step) % span;
    end while (pos != step);
    return 1'b0;
  endfunction

  function automatic table_reply_t predict_request(input logic [CMD_W-1:0] cmd,
                                                   input bit [KEY_W-1:0] key);
    int unsigned span;
    int unsigned where;
    bit [KEY_W-1:0] cand;
    table_reply_t r;
    span = active_span();
    r.key = key;
    r.slot = '0;
    r.status = ST_NOT_FOUND;
    case (cmd)
      CMD_ALLOC: begin
        r.key = '0;
        r.status = ST_FULL;
        if (stored_count < span) begin
          cand = key_counter + 1;
          while (cand % span == 0) cand = cand + 1;
          if (walk_probe(cand, '0, span, where)) begin
            key_store[where] = cand;
            stored_count++;
            key_counter = cand;
            r.key = cand;
            r.slot = where[SLOT_W-1:0];
            r.status = ST_DONE;
          end
        end
      end
      CMD_LOOKUP, CMD_DELETE: begin
        if (key != 0 && walk_probe(key, key, span, where)) begin
          r.slot = where[SLOT_W-1:0];
          r.status = ST_DONE;
          if (cmd == CMD_DELETE) begin
            key_store[where] = '0;
            if (stored_count > 0) stored_count--;
          end
        end
      end
      default: ;
    endcase
    r.occ = stored_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic int field_mismatch(input string field, input logic [KEY_W-1:0] want,
                                        input logic [KEY_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    int errs;
    errs = 0;
    if (!rst_n) begin
      foreach (key_store[i]) key_store[i] = '0;
      stored_count = 0;
      key_counter = '0;
      size_setting = SIZE_RESET;
      replies_due.delete();
      results_seen <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == SIZE_ADDR)
        size_setting = cfg_pwdata[SIZE_W-1:0];
      if (in_tvalid && in_tready)
        replies_due.push_back(predict_request(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        if (replies_due.size() == 0) begin
          $error("unexpected result: tdata %h, tuser %h", out_tdata, out_tuser);
          errs = 1;
        end else begin
          want = replies_due.pop_front();
          errs += field_mismatch("result_key", want.key, out_tdata[KEY_W-1:0]);
          errs += field_mismatch("slot", want.slot, out_tdata[KEY_W +: SLOT_W]);
          errs += field_mismatch("occupancy", want.occ, out_tdata[OCC_LSB +: OCC_W]);
          errs += field_mismatch("tdata padding", '0, out_tdata[OUT_DATA_W-1:PAD_LSB]);
          errs += field_mismatch("status", want.status, out_tuser);
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end

endmodule

@@ tb/sv/open_address_key_table_tb.sv @@
module open_address_key_table_tb;
  import oakt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0]      CMD_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] SIZE_ADDR  = {REG_TABLE_SIZE, 2'b00};
  localparam int                    LONG_HOLD  = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [KEY_W-1:0]      in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = CMD_ALLOC;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int             accepted = 0;
  int             results_seen;
  int             fail_count;
  bit             steady = 1'b0;
  bit             long_hold_done = 1'b0;
  logic [KEY_W-1:0] recent_keys [$];

  always #5 clk = ~clk;

  open_address_key_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  open_address_key_table_checker table_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_pready(cfg_pready),
    .results_seen(results_seen), .fail_count(fail_count)
  );

  // keys that recently hit or were allocated, so lookups and deletes find something
  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready && out_tuser == ST_DONE) begin
      recent_keys.push_back(out_tdata[KEY_W-1:0]);
      if (recent_keys.size() > 48) recent_keys.pop_front();
    end

  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= key;
    do @(posedge clk); while (!in_tready);
    accepted++;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (results_seen != accepted) @(posedge clk);
  endtask

  task automatic write_table_size(input logic [SIZE_W-1:0] span);
    logic [CFG_DATA_W-1:0] word;
    word = $urandom;
    word[SIZE_W-1:0] = span;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= SIZE_ADDR;
    cfg_pwdata <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] span, input int count, input bit no_gaps);
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int r;
    wait_drained();
    write_table_size(span);
    steady = no_gaps;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 40) cmd = CMD_ALLOC;
      else if (r < 70) cmd = CMD_LOOKUP;
      else if (r < 94) cmd = CMD_DELETE;
      else cmd = CMD_UNUSED;
      r = $urandom_range(0, 99);
      if (r < 65 && recent_keys.size() > 0)
        key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      else if (r < 85) key = $urandom_range(0, 400);
      else key = $urandom;
      send_request(cmd, key);
    end
  endtask

  initial begin : result_sink
    int run;
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      run = $urandom_range(1, 40);
      repeat (run) @(posedge clk);
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1'b1;
        gap = LONG_HOLD;
      end else begin
        gap = gap_len();
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset size; keys 1..3 land in slots 1..3, all removed again by the end
    send_request(CMD_ALLOC, 32'hFFFF_FFFF);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_ALLOC, 32'h1234_5678);
    send_request(CMD_LOOKUP, 32'd1);
    send_request(CMD_LOOKUP, 32'd3);
    send_request(CMD_LOOKUP, '0);
    send_request(CMD_DELETE, '0);
    send_request(CMD_LOOKUP, 32'hFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'd1021);
    send_request(CMD_DELETE, 32'd2);
    send_request(CMD_DELETE, 32'd2);
    send_request(CMD_LOOKUP, 32'd2);
    send_request(CMD_UNUSED, 32'hAAAA_AAAA);
    send_request(CMD_UNUSED, 32'h5555_5555);
    send_request(CMD_ALLOC, '0);
    send_request(CMD_DELETE, 32'd1);
    send_request(CMD_DELETE, 32'd3);
    send_request(CMD_DELETE, 32'd4);
    send_request(CMD_LOOKUP, 32'h8000_0000);

    // sizes mostly ascending so stored keys stay reachable; 1021 and the last one lower it again
    run_phase(11'd2,    60, 1'b0);
    run_phase(11'd1,    40, 1'b0);
    run_phase(11'd0,    30, 1'b1);
    run_phase(11'd3,    50, 1'b0);
    run_phase(11'd4,    50, 1'b0);
    run_phase(11'd5,    50, 1'b0);
    run_phase(11'd7,    60, 1'b1);
    run_phase(11'd12,   60, 1'b0);
    run_phase(11'd13,   60, 1'b0);
    run_phase(11'd31,   70, 1'b0);
    run_phase(11'd64,   50, 1'b1);
    run_phase(11'd127,  60, 1'b0);
    run_phase(11'd2047, 20, 1'b0);
    run_phase(11'd1021, 25, 1'b0);
    run_phase(11'd1024, 20, 1'b1);
    run_phase(11'd5,    40, 1'b0);

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("[open_address_key_table] OK");
    end else begin
      $display("[open_address_key_table] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("[open_address_key_table] ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/oakt_pkg.sv
src/oakt_mod.sv
src/oakt_ram.sv
src/open_address_key_table.sv
tb/sv/open_address_key_table_checker.sv
tb/sv/open_address_key_table_tb.sv
